// File: rtl/core/mhpq_pkg.sv
// Shared types and codes for the min-heap priority queue core.
package mhpq_pkg;

    localparam int CMD_WIDTH    = 2;
    localparam int TAG_WIDTH    = 6;
    localparam int STATUS_WIDTH = 2;

    typedef logic [CMD_WIDTH-1:0]    cmd_t;
    typedef logic [STATUS_WIDTH-1:0] status_t;

    // Operation codes carried on s_tuser
    localparam cmd_t CMD_PUSH    = 2'd0;
    localparam cmd_t CMD_BUILD   = 2'd1;
    localparam cmd_t CMD_EXTRACT = 2'd2;
    localparam cmd_t CMD_SORT    = 2'd3;

    // Result status codes
    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_EMPTY = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;

endpackage

// File: rtl/core/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
    parameter int DATA_WIDTH = 38,
    parameter int DEPTH      = 64
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [DATA_WIDTH-1:0]         wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [DATA_WIDTH-1:0]         rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/min_heap_priority_queue_core.sv
// Min-heap priority queue core: binary heap in one RAM, push/build/extract/heapsort.
// Push and empty-heap commands: accepted in IDLE, result registered in RESP once m_* is free.
// Extract: read the root, then the last entry, then sift that entry down from the root.
// Build: sift down each of the n/2 inner nodes in turn; sort: build, then swap root and sift per
// entry, then emit each entry. One command is worked at a time; a result can wait in m_*.
// Reset (aresetn low, synchronous) empties the heap; RAM contents are left as they are.
module min_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = 64,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    // s_tdata: key, tag (from bit 0 up), zero padded to bytes
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    input  logic [((KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0]         s_tdata,
    // s_tuser: cmd
    input  logic [CMD_WIDTH-1:0]                             s_tuser,
    // m_tdata: key_out, tag_out, count_out (from bit 0 up), zero padded to bytes
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    output logic [((KEY_WIDTH+TAG_WIDTH+$clog2(HEAP_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // m_tuser: has_entry, status (from bit 0 up)
    output logic [STATUS_WIDTH:0]                            m_tuser,
    output logic                                             m_tlast
);

    localparam int AW  = $clog2(HEAP_DEPTH);
    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int CHW = AW + 2;
    localparam int EW  = KEY_WIDTH + TAG_WIDTH;
    localparam int MDW = ((KEY_WIDTH + TAG_WIDTH + CW + 7) / 8) * 8;

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_RESP     = 4'd1;
    localparam logic [ST_W-1:0] ST_BLD_RD   = 4'd2;
    localparam logic [ST_W-1:0] ST_BLD_CUR  = 4'd3;
    localparam logic [ST_W-1:0] ST_SFT_RL   = 4'd4;
    localparam logic [ST_W-1:0] ST_SFT_RR   = 4'd5;
    localparam logic [ST_W-1:0] ST_SFT_CMP  = 4'd6;
    localparam logic [ST_W-1:0] ST_EXT_RD0  = 4'd7;
    localparam logic [ST_W-1:0] ST_EXT_RDL  = 4'd8;
    localparam logic [ST_W-1:0] ST_EXT_LAST = 4'd9;
    localparam logic [ST_W-1:0] ST_SRT_RD0  = 4'd10;
    localparam logic [ST_W-1:0] ST_SRT_RDJ  = 4'd11;
    localparam logic [ST_W-1:0] ST_SRT_SWP  = 4'd12;
    localparam logic [ST_W-1:0] ST_EM_RD    = 4'd13;
    localparam logic [ST_W-1:0] ST_EM_OUT   = 4'd14;

    // Control registers
    logic [ST_W-1:0]      state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 phase_reg, phase_next;   // sort: 0 heapify, 1 swap-and-sift
    logic                 m_tvalid_reg, m_tvalid_next;

    // Payload registers
    cmd_t                 cmd_reg, cmd_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        size_reg, size_next;
    logic [AW-1:0]        node_reg, node_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [EW-1:0]        cur_reg, cur_next;
    logic [EW-1:0]        lk_reg, lk_next;
    logic [KEY_WIDTH-1:0] resp_key_reg, resp_key_next;
    logic [TAG_WIDTH-1:0] resp_tag_reg, resp_tag_next;
    logic                 resp_has_reg, resp_has_next;
    status_t              resp_status_reg, resp_status_next;
    logic [MDW-1:0]       m_tdata_reg, m_tdata_next;
    logic [STATUS_WIDTH:0] m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    // RAM port
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [EW-1:0]        ram_wdata, ram_rdata;

    // Datapath helpers
    logic [KEY_WIDTH-1:0] s_key;
    logic [TAG_WIDTH-1:0] s_tag;
    logic [CHW-1:0]       lc_w, rc_w, size_w;
    logic                 lc_in, rc_in;
    logic                 left_win, right_win;
    logic [EW-1:0]        win_entry;
    logic                 out_free;
    logic                 sift_done;
    logic                 em_last;

    mhpq_ram #(
        .DATA_WIDTH (EW),
        .DEPTH      (HEAP_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_key = s_tdata[KEY_WIDTH-1:0];
    assign s_tag = s_tdata[KEY_WIDTH +: TAG_WIDTH];

    // Child indexes of the current node and their range checks
    assign lc_w   = {1'b0, node_reg, 1'b1};
    assign rc_w   = lc_w + CHW'(1);
    assign size_w = CHW'(size_reg);
    assign lc_in  = lc_w < size_w;
    assign rc_in  = rc_w < size_w;

    // Child selection: lk_reg holds the left child, ram_rdata the right child
    assign left_win  = $signed(lk_reg[EW-1:TAG_WIDTH]) < $signed(cur_reg[EW-1:TAG_WIDTH]);
    assign win_entry = left_win ? lk_reg : cur_reg;
    assign right_win = rc_in &&
        ($signed(ram_rdata[EW-1:TAG_WIDTH]) < $signed(win_entry[EW-1:TAG_WIDTH]));

    assign out_free = !m_tvalid_reg || m_tready;
    assign em_last  = (CW'(idx_reg) + CW'(1)) == n_reg;
    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        phase_next       = phase_reg;
        cmd_next         = cmd_reg;
        n_next           = n_reg;
        size_next        = size_reg;
        node_next        = node_reg;
        idx_next         = idx_reg;
        cur_next         = cur_reg;
        lk_next          = lk_reg;
        resp_key_next    = resp_key_reg;
        resp_tag_next    = resp_tag_reg;
        resp_has_next    = resp_has_reg;
        resp_status_next = resp_status_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        m_tlast_next     = m_tlast_reg;
        ram_we           = 1'b0;
        ram_waddr        = node_reg;
        ram_wdata        = cur_reg;
        ram_re           = 1'b0;
        ram_raddr        = '0;
        sift_done        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next         = s_tuser;
                    resp_key_next    = '0;
                    resp_tag_next    = '0;
                    resp_has_next    = 1'b0;
                    resp_status_next = STAT_OK;
                    state_next       = ST_RESP;
                    n_next           = count_reg;
                    size_next        = count_reg;
                    phase_next       = 1'b0;
                    case (s_tuser)
                        CMD_PUSH: begin
                            if (count_reg == CW'(HEAP_DEPTH)) begin
                                resp_status_next = STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = {s_key, s_tag};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_EXTRACT, CMD_SORT: begin
                            if (count_reg == '0) begin
                                resp_key_next    = {1'b0, {(KEY_WIDTH-1){1'b1}}};
                                resp_status_next = STAT_EMPTY;
                            end else if (s_tuser == CMD_EXTRACT) begin
                                state_next = ST_EXT_RD0;
                            end else if ((count_reg >> 1) == '0) begin
                                // single entry: already sorted
                                idx_next   = '0;
                                count_next = '0;
                                state_next = ST_EM_RD;
                            end else begin
                                idx_next   = AW'((count_reg >> 1) - CW'(1));
                                state_next = ST_BLD_RD;
                            end
                        end
                        default: begin
                            // build heap
                            if ((count_reg >> 1) != '0) begin
                                idx_next   = AW'((count_reg >> 1) - CW'(1));
                                state_next = ST_BLD_RD;
                            end
                        end
                    endcase
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = MDW'({count_reg, resp_tag_reg, resp_key_reg});
                    m_tuser_next  = {resp_status_reg, resp_has_reg};
                    m_tlast_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            // Heapify: load the node to sift
            ST_BLD_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = ST_BLD_CUR;
            end
            ST_BLD_CUR: begin
                cur_next   = ram_rdata;
                node_next  = idx_reg;
                state_next = ST_SFT_RL;
            end

            // Sift-down, hole style: cur_reg is written once at its final slot
            ST_SFT_RL: begin
                if (lc_in) begin
                    ram_re     = 1'b1;
                    ram_raddr  = lc_w[AW-1:0];
                    state_next = ST_SFT_RR;
                end else begin
                    ram_we    = 1'b1;
                    sift_done = 1'b1;
                end
            end
            ST_SFT_RR: begin
                lk_next    = ram_rdata;
                ram_re     = rc_in;
                ram_raddr  = rc_w[AW-1:0];
                state_next = ST_SFT_CMP;
            end
            ST_SFT_CMP: begin
                ram_we = 1'b1;
                if (right_win) begin
                    ram_wdata  = ram_rdata;
                    node_next  = rc_w[AW-1:0];
                    state_next = ST_SFT_RL;
                end else if (left_win) begin
                    ram_wdata  = lk_reg;
                    node_next  = lc_w[AW-1:0];
                    state_next = ST_SFT_RL;
                end else begin
                    sift_done = 1'b1;
                end
            end

            // Extract: take the root, sift the last entry from the root
            ST_EXT_RD0: begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = ST_EXT_RDL;
            end
            ST_EXT_RDL: begin
                resp_key_next = ram_rdata[EW-1:TAG_WIDTH];
                resp_tag_next = ram_rdata[TAG_WIDTH-1:0];
                resp_has_next = 1'b1;
                ram_re        = 1'b1;
                ram_raddr     = AW'(count_reg - CW'(1));
                state_next    = ST_EXT_LAST;
            end
            ST_EXT_LAST: begin
                cur_next   = ram_rdata;
                count_next = count_reg - CW'(1);
                size_next  = count_reg - CW'(1);
                node_next  = '0;
                state_next = ST_SFT_RL;
            end

            // Heapsort step: swap root with slot idx, sift over idx entries
            ST_SRT_RD0: begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = ST_SRT_RDJ;
            end
            ST_SRT_RDJ: begin
                lk_next    = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = ST_SRT_SWP;
            end
            ST_SRT_SWP: begin
                cur_next   = ram_rdata;
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = lk_reg;
                node_next  = '0;
                size_next  = CW'(idx_reg);
                state_next = ST_SFT_RL;
            end

            // Emit the sorted run, slot 0 first
            ST_EM_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = MDW'({count_reg, ram_rdata[TAG_WIDTH-1:0],
                                          ram_rdata[EW-1:TAG_WIDTH]});
                    m_tuser_next  = {STAT_OK, 1'b1};
                    m_tlast_next  = em_last;
                    idx_next      = idx_reg + AW'(1);
                    state_next    = em_last ? ST_IDLE : ST_EM_RD;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Continue after a sift-down finishes
        if (sift_done) begin
            if (cmd_reg == CMD_EXTRACT) begin
                state_next = ST_RESP;
            end else if (!phase_reg) begin
                if (idx_reg != '0) begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = ST_BLD_RD;
                end else if (cmd_reg == CMD_BUILD) begin
                    state_next = ST_RESP;
                end else begin
                    phase_next = 1'b1;
                    idx_next   = AW'(n_reg - CW'(1));
                    state_next = ST_SRT_RD0;
                end
            end else if (idx_reg == AW'(1)) begin
                idx_next   = '0;
                count_next = '0;
                state_next = ST_EM_RD;
            end else begin
                idx_next   = idx_reg - AW'(1);
                state_next = ST_SRT_RD0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            phase_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        n_reg           <= n_next;
        size_reg        <= size_next;
        node_reg        <= node_next;
        idx_reg         <= idx_next;
        cur_reg         <= cur_next;
        lk_reg          <= lk_next;
        resp_key_reg    <= resp_key_next;
        resp_tag_reg    <= resp_tag_next;
        resp_has_reg    <= resp_has_next;
        resp_status_reg <= resp_status_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
        m_tlast_reg     <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Entry count never passes the store size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("entry count beyond heap depth");

    // No read and write of the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("RAM read and write hit the same slot");

    // Compared node always lies inside the active heap
    a_node_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SFT_CMP) |-> (CHW'(node_reg) < size_w))
        else $error("sift node outside active heap");

    // Sorted run is emitted with the heap already emptied
    a_emit_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EM_OUT) |-> (count_reg == '0))
        else $error("emit with entries still counted");

endmodule
